@@ src/keyword_longest_match_unit_assert.svh @@
// Assertion macros for the keyword longest match unit.
// Used by the port checker; expects signals clk and rst_n in scope.
`ifndef KEYWORD_LONGEST_MATCH_UNIT_ASSERT_SVH
`define KEYWORD_LONGEST_MATCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyword match unit: port rule violated");

// Next-cycle implication, checked outside reset.
`define KLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyword match unit: port rule violated next cycle");

`endif

@@ src/klm_pkg.sv @@
// Shared types and constants for the keyword longest match unit.
// No dependencies.
package klm_pkg;

  localparam int KEYWORDS_DEF = 16;
  localparam int KEY_LEN_DEF  = 16;
  localparam int LEN_W        = 7;   // holds lengths and positions up to 127
  localparam int CHR_W        = 8;
  localparam int ID_W         = 8;
  localparam int ENT_W        = 9;   // holds entry counts up to 511

  localparam logic [CHR_W-1:0] WILDCARD = 8'h3F;
  localparam logic [CHR_W-1:0] LOWER_A  = 8'h61;
  localparam logic [CHR_W-1:0] LOWER_Z  = 8'h7A;
  localparam logic [CHR_W-1:0] CASE_OFS = 8'h20;
  localparam logic [CHR_W-1:0] SPACE    = 8'h20;
  localparam logic [CHR_W-1:0] WS_LO    = 8'h09;
  localparam logic [CHR_W-1:0] WS_HI    = 8'h0D;

  typedef enum logic [1:0] {
    CMD_LOAD_CHR = 2'd0,
    CMD_LOAD_LEN = 2'd1,
    CMD_STREAM   = 2'd2,
    CMD_END      = 2'd3
  } klm_cmd_t;

  typedef enum logic [1:0] {
    REG_CASE_FOLD  = 2'd0,
    REG_SKIP_WHITE = 2'd1,
    REG_DEFAULT_ID = 2'd2,
    REG_KEY_COUNT  = 2'd3
  } klm_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_WALK,
    S_PFX,
    S_FIN,
    S_NXT,
    S_END
  } klm_state_t;

  // table write broadcast to all cells
  typedef struct packed {
    logic             chr_en;
    logic             len_en;
    logic [ENT_W-1:0] entry;
    logic [LEN_W-1:0] pos;
    logic [CHR_W-1:0] chr;
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  id;
  } klm_wr_t;

  // read data passed along the cell chain
  typedef struct packed {
    logic [CHR_W-1:0] chr_a;
    logic [LEN_W-1:0] len_a;
    logic [ID_W-1:0]  id_a;
    logic [CHR_W-1:0] chr_b;
    logic [LEN_W-1:0] len_b;
  } klm_rd_t;

endpackage

@@ src/klm_cell.sv @@
// One keyword table entry: characters, length and identifier.
// Depends on klm_pkg. Read data ripples from the previous cell to the next.
module klm_cell #(
  parameter int KEY_LEN = klm_pkg::KEY_LEN_DEF,
  parameter int IDX     = 0,
  parameter int CW      = 5
) (
  input  logic                      clk,
  input  klm_pkg::klm_wr_t          wr,
  input  logic [CW-1:0]             idx_a,
  input  logic [CW-1:0]             idx_b,
  input  logic [klm_pkg::LEN_W-1:0] rd_pos,
  input  klm_pkg::klm_rd_t          rd_in,
  output klm_pkg::klm_rd_t          rd_out
);

  localparam int PW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

  logic [klm_pkg::CHR_W-1:0] chr_r [KEY_LEN];
  logic [klm_pkg::LEN_W-1:0] len_r;
  logic [klm_pkg::ID_W-1:0]  id_r;
  logic [klm_pkg::CHR_W-1:0] own_chr;
  logic                      hit;

  assign hit = (wr.entry == klm_pkg::ENT_W'(IDX));

  always_ff @(posedge clk) begin
    if (wr.chr_en && hit) begin
      chr_r[wr.pos[PW-1:0]] <= wr.chr;
    end
    if (wr.len_en && hit) begin
      len_r <= wr.len;
      id_r  <= wr.id;
    end
  end

  // positions past the keyword read as code 0
  assign own_chr = (rd_pos < len_r) ? chr_r[rd_pos[PW-1:0]] : '0;

  always_comb begin
    rd_out = rd_in;
    if (idx_a == CW'(IDX)) begin
      rd_out.chr_a = own_chr;
      rd_out.len_a = len_r;
      rd_out.id_a  = id_r;
    end
    if (idx_b == CW'(IDX)) begin
      rd_out.chr_b = own_chr;
      rd_out.len_b = len_r;
    end
  end

endmodule

@@ src/keyword_longest_match_unit.sv @@
// Top level of the keyword longest match unit: control sequencer,
// configuration registers and the chain of klm_cell entries. Depends on klm_pkg.
//
//  channel | direction | handshake
//  in_*    | in        | start / busy, taken when start & !busy
//  out_*   | out       | out_valid strobe, one cycle, no back pressure
//  cfg     | in / out  | APB psel / penable / pwrite, pready tied high
//
// Loads and stream ends are taken in idle; a stream end's result appears in the next cycle.
// A stream character steps through check, a walk of the sorted table, a prefix
// compare of the two entries, finish, an optional compare with the next entry and end,
// one position of one entry pair per cycle through the cell chain.
// Reset is synchronous and sets only configuration and sequencer state; table contents are
// undefined until loaded. Results cannot be stalled.
module keyword_longest_match_unit #(
  parameter int KEYWORDS = klm_pkg::KEYWORDS_DEF,
  parameter int KEY_LEN  = klm_pkg::KEY_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_entry,
  input  logic [3:0]  in_position,
  input  logic [7:0]  in_char_value,
  input  logic [4:0]  in_key_length,
  input  logic [7:0]  in_key_id,
  output logic        out_valid,
  output logic        out_found,
  output logic [7:0]  out_identifier,
  output logic [4:0]  out_match_length,
  output logic        out_end_consumed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(KEYWORDS + 1);
  localparam int LW = klm_pkg::LEN_W;

  klm_pkg::klm_state_t state_r, state_nxt;

  logic            case_fold_r, skip_white_r;
  logic [7:0]      default_id_r;
  logic [4:0]      key_count_r;

  logic [7:0]      c_r, c_nxt;
  logic [CW-1:0]   k_r, k_nxt, p_r, p_nxt, cand_r, cand_nxt;
  logic [LW-1:0]   i_r, i_nxt, j_r, j_nxt, pos_r, pos_nxt;
  logic            match_r, match_nxt, more_r, more_nxt;
  logic [7:0]      best_id_r, best_id_nxt;
  logic [LW-1:0]   best_len_r, best_len_nxt;
  logic            have_best_r, have_best_nxt, in_match_r, in_match_nxt;
  logic            out_valid_r, out_valid_nxt, found_r, found_nxt;
  logic [7:0]      ident_r, ident_nxt;
  logic [4:0]      mlen_r, mlen_nxt;
  logic            cons_r, cons_nxt;

  logic [CW-1:0]   n;
  logic [klm_pkg::ENT_W-1:0] n_full;
  logic            accept, white, emit;
  logic            emit_cons;
  logic [7:0]      folded;
  logic [LW-1:0]   rd_pos, i_inc;
  klm_pkg::klm_wr_t wr;
  klm_pkg::klm_rd_t rd [KEYWORDS+1];

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_fold_r  <= 1'b1;
      skip_white_r <= 1'b1;
      default_id_r <= 8'hFF;
      key_count_r  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (klm_pkg::klm_reg_t'(paddr[3:2]))
        klm_pkg::REG_CASE_FOLD:  case_fold_r  <= pwdata[0];
        klm_pkg::REG_SKIP_WHITE: skip_white_r <= pwdata[0];
        klm_pkg::REG_DEFAULT_ID: default_id_r <= pwdata[7:0];
        klm_pkg::REG_KEY_COUNT:  key_count_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (klm_pkg::klm_reg_t'(paddr[3:2]))
      klm_pkg::REG_CASE_FOLD:  prdata = {31'b0, case_fold_r};
      klm_pkg::REG_SKIP_WHITE: prdata = {31'b0, skip_white_r};
      klm_pkg::REG_DEFAULT_ID: prdata = {24'b0, default_id_r};
      klm_pkg::REG_KEY_COUNT:  prdata = {27'b0, key_count_r};
      default:                 prdata = '0;
    endcase
  end

  // ---------------- cell chain ----------------
  assign accept = start && (state_r == klm_pkg::S_IDLE);

  always_comb begin
    wr.chr_en = accept && (klm_pkg::klm_cmd_t'(in_cmd) == klm_pkg::CMD_LOAD_CHR) &&
                ({5'b0, in_entry} < klm_pkg::ENT_W'(KEYWORDS)) &&
                ({3'b0, in_position} < LW'(KEY_LEN));
    wr.len_en = accept && (klm_pkg::klm_cmd_t'(in_cmd) == klm_pkg::CMD_LOAD_LEN) &&
                ({5'b0, in_entry} < klm_pkg::ENT_W'(KEYWORDS));
    wr.entry  = {5'b0, in_entry};
    wr.pos    = {3'b0, in_position};
    wr.chr    = in_char_value;
    wr.len    = ({2'b0, in_key_length} > LW'(KEY_LEN)) ? LW'(KEY_LEN)
                                                      : {2'b0, in_key_length};
    wr.id     = in_key_id;
  end

  assign rd_pos = (state_r == klm_pkg::S_PFX || state_r == klm_pkg::S_NXT) ? j_r : i_r;
  assign rd[0]  = '0;

  for (genvar g = 0; g < KEYWORDS; g++) begin : g_cell
    klm_cell #(.KEY_LEN(KEY_LEN), .IDX(g), .CW(CW)) u_cell (
      .clk    (clk),
      .wr     (wr),
      .idx_a  (k_r),
      .idx_b  (p_r),
      .rd_pos (rd_pos),
      .rd_in  (rd[g]),
      .rd_out (rd[g+1])
    );
  end

  // ---------------- sequencer ----------------
  assign n_full = ({4'b0, key_count_r} > klm_pkg::ENT_W'(KEYWORDS))
                  ? klm_pkg::ENT_W'(KEYWORDS) : {4'b0, key_count_r};
  assign n      = n_full[CW-1:0];
  assign white  = (in_char_value == klm_pkg::SPACE) ||
                  (in_char_value >= klm_pkg::WS_LO && in_char_value <= klm_pkg::WS_HI);
  assign folded = (case_fold_r && in_char_value >= klm_pkg::LOWER_A &&
                   in_char_value <= klm_pkg::LOWER_Z)
                  ? in_char_value - klm_pkg::CASE_OFS : in_char_value;
  assign i_inc  = i_r + LW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      klm_pkg::S_IDLE: begin
        if (accept && klm_pkg::klm_cmd_t'(in_cmd) == klm_pkg::CMD_STREAM &&
            !(!in_match_r && skip_white_r && white)) begin
          state_nxt = klm_pkg::S_CHK;
        end
      end
      klm_pkg::S_CHK: begin
        if (k_r < n && !(rd[KEYWORDS].chr_a == klm_pkg::WILDCARD ||
            (i_r < rd[KEYWORDS].len_a && rd[KEYWORDS].chr_a == c_r))) begin
          state_nxt = klm_pkg::S_WALK;
        end else begin
          state_nxt = klm_pkg::S_FIN;
        end
      end
      klm_pkg::S_WALK: begin
        if (p_r < n && c_r > rd[KEYWORDS].chr_b) begin
          state_nxt = klm_pkg::S_WALK;
        end else if (p_r < n && i_r < rd[KEYWORDS].len_b && rd[KEYWORDS].chr_b == c_r) begin
          state_nxt = klm_pkg::S_PFX;
        end else begin
          state_nxt = klm_pkg::S_FIN;
        end
      end
      klm_pkg::S_PFX: begin
        if (j_r >= i_r || rd[KEYWORDS].chr_a != rd[KEYWORDS].chr_b) begin
          state_nxt = klm_pkg::S_FIN;
        end
      end
      klm_pkg::S_FIN: begin
        if (!more_r && match_r && (k_r + CW'(1)) < n) begin
          state_nxt = klm_pkg::S_NXT;
        end else begin
          state_nxt = klm_pkg::S_END;
        end
      end
      klm_pkg::S_NXT: begin
        if (rd[KEYWORDS].chr_a != rd[KEYWORDS].chr_b || j_r == i_r) begin
          state_nxt = klm_pkg::S_END;
        end
      end
      klm_pkg::S_END:  state_nxt = klm_pkg::S_IDLE;
      default:         state_nxt = klm_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    c_nxt         = c_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    match_nxt     = match_r;
    more_nxt      = more_r;
    cand_nxt      = cand_r;
    pos_nxt       = pos_r;
    best_id_nxt   = best_id_r;
    best_len_nxt  = best_len_r;
    have_best_nxt = have_best_r;
    in_match_nxt  = in_match_r;
    emit          = 1'b0;
    emit_cons     = 1'b0;
    unique case (state_r)
      klm_pkg::S_IDLE: begin
        if (accept && klm_pkg::klm_cmd_t'(in_cmd) == klm_pkg::CMD_STREAM &&
            !(!in_match_r && skip_white_r && white)) begin
          in_match_nxt = 1'b1;
          c_nxt        = folded;
          k_nxt        = cand_r;
          i_nxt        = pos_r;
        end else if (accept && klm_pkg::klm_cmd_t'(in_cmd) == klm_pkg::CMD_END) begin
          emit = 1'b1;
        end
      end
      klm_pkg::S_CHK: begin
        match_nxt = (k_r < n) && (rd[KEYWORDS].chr_a == klm_pkg::WILDCARD ||
                    (i_r < rd[KEYWORDS].len_a && rd[KEYWORDS].chr_a == c_r));
        more_nxt  = (k_r < n) && (i_inc < rd[KEYWORDS].len_a);
        p_nxt     = k_r;
      end
      klm_pkg::S_WALK: begin
        j_nxt = '0;
        if (p_r < n && c_r > rd[KEYWORDS].chr_b) begin
          p_nxt = p_r + CW'(1);
        end else if (!(p_r < n && i_r < rd[KEYWORDS].len_b &&
                       rd[KEYWORDS].chr_b == c_r)) begin
          match_nxt = 1'b0;
        end
      end
      klm_pkg::S_PFX: begin
        if (j_r >= i_r) begin
          match_nxt = 1'b1;
          k_nxt     = p_r;
          more_nxt  = i_inc < rd[KEYWORDS].len_b;
        end else if (rd[KEYWORDS].chr_a != rd[KEYWORDS].chr_b) begin
          match_nxt = 1'b0;
        end else begin
          j_nxt = j_r + LW'(1);
        end
      end
      klm_pkg::S_FIN: begin
        if (!more_r && match_r) begin
          have_best_nxt = 1'b1;
          best_id_nxt   = rd[KEYWORDS].id_a;
          best_len_nxt  = i_inc;
          p_nxt         = k_r + CW'(1);
          j_nxt         = '0;
        end
      end
      klm_pkg::S_NXT: begin
        if (rd[KEYWORDS].chr_a == rd[KEYWORDS].chr_b) begin
          if (j_r == i_r) begin
            more_nxt = 1'b1;
            k_nxt    = p_r;
          end else begin
            j_nxt = j_r + LW'(1);
          end
        end
      end
      klm_pkg::S_END: begin
        if (match_r && more_r) begin
          cand_nxt = k_r;
          pos_nxt  = i_inc;
        end else begin
          emit      = 1'b1;
          emit_cons = match_r && !more_r;
        end
      end
      default: ;
    endcase
    if (emit) begin
      cand_nxt      = '0;
      pos_nxt       = '0;
      best_id_nxt   = '0;
      best_len_nxt  = '0;
      have_best_nxt = 1'b0;
      in_match_nxt  = 1'b0;
    end
  end

  // outputs
  always_comb begin
    busy          = (state_r != klm_pkg::S_IDLE);
    out_valid_nxt = emit;
    found_nxt     = have_best_r;
    ident_nxt     = have_best_r ? best_id_r : default_id_r;
    mlen_nxt      = have_best_r ? best_len_r[4:0] : 5'd0;
    cons_nxt      = emit_cons;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= klm_pkg::S_IDLE;
      cand_r      <= '0;
      pos_r       <= '0;
      best_id_r   <= '0;
      best_len_r  <= '0;
      have_best_r <= 1'b0;
      in_match_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cand_r      <= cand_nxt;
      pos_r       <= pos_nxt;
      best_id_r   <= best_id_nxt;
      best_len_r  <= best_len_nxt;
      have_best_r <= have_best_nxt;
      in_match_r  <= in_match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    match_r <= match_nxt;
    more_r  <= more_nxt;
    found_r <= found_nxt;
    ident_r <= ident_nxt;
    mlen_r  <= mlen_nxt;
    cons_r  <= cons_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_identifier   = ident_r;
  assign out_match_length = mlen_r;
  assign out_end_consumed = cons_r;

endmodule

@@ src/klm_port_check.sv @@
// Port-level checker for keyword_longest_match_unit, bound to the top level.
// Depends on keyword_longest_match_unit_assert.svh.
`include "keyword_longest_match_unit_assert.svh"

module klm_port_check (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_found,
  input logic [4:0] out_match_length,
  input logic       out_end_consumed
);

  `KLM_ASSERT_IMP(a_nofound_len, out_valid && !out_found, out_match_length == 5'd0)
  `KLM_ASSERT_IMP(a_found_len, out_valid && out_found, out_match_length != 5'd0)
  `KLM_ASSERT_IMP(a_cons_found, out_valid && out_end_consumed, out_found)
  `KLM_ASSERT_NXT(a_busy_rise, !busy && !start, !busy)
  `KLM_ASSERT_NXT(a_idle_quiet, !busy && !start, !out_valid)

endmodule

bind keyword_longest_match_unit klm_port_check u_klm_port_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_found        (out_found),
  .out_match_length (out_match_length),
  .out_end_consumed (out_end_consumed)
);

@@ test/klm_match_checker.sv @@
// Result checker for the keyword longest match unit: tracks table loads, register
// writes and stream items, predicts each match report and compares it.
// Depends on klm_pkg.
`timescale 1ns / 1ps

module klm_match_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_entry,
  input  logic [3:0] in_position,
  input  logic [7:0] in_char_value,
  input  logic [4:0] in_key_length,
  input  logic [7:0] in_key_id,
  input  logic       out_valid,
  input  logic       out_found,
  input  logic [7:0] out_identifier,
  input  logic [4:0] out_match_length,
  input  logic       out_end_consumed,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic       pready,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output int         fail_count,
  output int         reports_pending
);

  typedef struct packed {
    logic       found;
    logic [7:0] ident;
    logic [4:0] mlen;
    logic       consumed;
  } match_report_t;

  match_report_t report_q[$];
  int            errs;

  logic [7:0] tbl_chr [16][16];
  logic [4:0] tbl_len [16];
  logic [7:0] tbl_id  [16];

  logic       fold, skip_ws;
  logic [7:0] dflt_id;
  logic [4:0] n_keys;

  int         cand, cpos;
  logic [7:0] best_id;
  logic [4:0] best_len;
  bit         have_best, matching;

  function automatic int eff_len(int k);
    return (tbl_len[k] > 16) ? 16 : int'(tbl_len[k]);
  endfunction

  function automatic int key_chr(int k, int pos);
    return (pos < eff_len(k)) ? int'(tbl_chr[k][pos]) : 0;
  endfunction

  function automatic bit key_same(int k, int pos, int c);
    return pos < eff_len(k) && key_chr(k, pos) == c;
  endfunction

  task automatic clear_walk();
    matching  = 0;
    cand      = 0;
    cpos      = 0;
    best_id   = '0;
    best_len  = '0;
    have_best = 0;
  endtask

  task automatic push_report(bit consumed);
    match_report_t r;
    r.found    = have_best;
    r.ident    = have_best ? best_id : dflt_id;
    r.mlen     = have_best ? best_len : 5'd0;
    r.consumed = consumed;
    report_q.push_back(r);
    clear_walk();
  endtask

  task automatic walk_char(logic [7:0] raw);
    int c, n, k, i, p, j;
    bit valid, hit, more, m, pre;
    if (!matching) begin
      if (skip_ws && (raw == klm_pkg::SPACE ||
                      (raw >= klm_pkg::WS_LO && raw <= klm_pkg::WS_HI))) return;
      clear_walk();
      matching = 1;
    end
    c = raw;
    if (fold && raw >= klm_pkg::LOWER_A && raw <= klm_pkg::LOWER_Z) c = c - klm_pkg::CASE_OFS;
    n = (n_keys > 16) ? 16 : int'(n_keys);
    k = cand;
    i = cpos;
    valid = k < n;
    hit = valid && (key_chr(k, i) == klm_pkg::WILDCARD || key_same(k, i, c));
    more = valid && i + 1 < eff_len(k);
    if (!hit && valid) begin
      p = k;
      while (p < n && c > key_chr(p, i)) p++;
      if (p < n) begin
        m = key_same(p, i, c);
        for (j = 0; j < i; j++) m = m && key_chr(k, j) == key_chr(p, j);
        hit = m;
        if (m) begin
          k = p;
          more = i + 1 < eff_len(p);
        end
      end
    end
    if (!more && hit) begin
      have_best = 1;
      best_id   = tbl_id[k];
      best_len  = 5'(i + 1);
      p = k + 1;
      pre = p < n;
      for (j = 0; pre && j <= i; j++) pre = key_chr(p, j) == key_chr(k, j);
      // a longer keyword shares this prefix: keep going
      if (pre) begin
        more = 1;
        k = p;
      end
    end
    if (hit && more) begin
      cand = k;
      cpos = i + 1;
    end else begin
      push_report(hit && !more);
    end
  endtask

  always @(posedge clk) begin
    match_report_t want;
    if (!rst_n) begin
      report_q.delete();
      fold    = 1;
      skip_ws = 1;
      dflt_id = 8'hFF;
      n_keys  = '0;
      for (int e = 0; e < 16; e++) begin
        tbl_len[e] = '0;
        tbl_id[e]  = '0;
        for (int q = 0; q < 16; q++) tbl_chr[e][q] = '0;
      end
      clear_walk();
    end else begin
      if (out_valid) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report found=%0d id=%0d len=%0d consumed=%0d", $time,
                   out_found, out_identifier, out_match_length, out_end_consumed);
          errs++;
        end else begin
          want = report_q.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
            errs++;
          end
          if (out_identifier !== want.ident) begin
            $display("%0t: identifier expected %0d actual %0d", $time, want.ident,
                     out_identifier);
            errs++;
          end
          if (out_match_length !== want.mlen) begin
            $display("%0t: match_length expected %0d actual %0d", $time, want.mlen,
                     out_match_length);
            errs++;
          end
          if (out_end_consumed !== want.consumed) begin
            $display("%0t: end_consumed expected %0d actual %0d", $time, want.consumed,
                     out_end_consumed);
            errs++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (klm_pkg::klm_reg_t'(paddr[3:2]))
          klm_pkg::REG_CASE_FOLD:  fold    = pwdata[0];
          klm_pkg::REG_SKIP_WHITE: skip_ws = pwdata[0];
          klm_pkg::REG_DEFAULT_ID: dflt_id = pwdata[7:0];
          klm_pkg::REG_KEY_COUNT:  n_keys  = pwdata[4:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (klm_pkg::klm_cmd_t'(in_cmd))
          klm_pkg::CMD_LOAD_CHR: tbl_chr[in_entry][in_position] = in_char_value;
          klm_pkg::CMD_LOAD_LEN: begin
            tbl_len[in_entry] = in_key_length;
            tbl_id[in_entry]  = in_key_id;
          end
          klm_pkg::CMD_STREAM: walk_char(in_char_value);
          default: begin
            if (!matching) clear_walk();
            push_report(0);
          end
        endcase
      end
    end
    fail_count      <= errs;
    reports_pending <= report_q.size();
  end

endmodule

@@ test/tb_keyword_longest_match_unit.sv @@
// Top of the keyword longest match unit testbench: clock, reset, APB register
// writes, table loads and character streams. Depends on klm_pkg, the unit and
// klm_match_checker.
`timescale 1ns / 1ps

module tb_keyword_longest_match_unit;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 120;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_cmd = klm_pkg::CMD_END;
  logic [3:0]  in_entry = '0;
  logic [3:0]  in_position = '0;
  logic [7:0]  in_char_value = '0;
  logic [4:0]  in_key_length = '0;
  logic [7:0]  in_key_id = '0;
  logic        out_valid, out_found, out_end_consumed;
  logic [7:0]  out_identifier;
  logic [4:0]  out_match_length;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, reports_pending;
  int          cycles = 0;
  int          stream_items = 0;

  logic [7:0] kw_chr [16][16];
  logic [4:0] kw_len [16];
  bit         fold_on;

  keyword_longest_match_unit dut (.*);

  klm_match_checker checker_i (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // start stays high from one item to the next unless an idle gap is taken
  task automatic send(klm_pkg::klm_cmd_t cmd, logic [3:0] ent, logic [3:0] pos,
                      logic [7:0] ch, logic [4:0] len, logic [7:0] id);
    if (!(stream_items >= 600 && stream_items < 900) && $urandom_range(99) < 8) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start         <= 1;
    in_cmd        <= cmd;
    in_entry      <= ent;
    in_position   <= pos;
    in_char_value <= ch;
    in_key_length <= len;
    in_key_id     <= id;
    do @(posedge clk); while (busy);
    if (cmd == klm_pkg::CMD_STREAM || cmd == klm_pkg::CMD_END) stream_items++;
  endtask

  task automatic put_char(logic [7:0] ch);
    send(klm_pkg::CMD_STREAM, 4'($urandom), 4'($urandom), ch, 5'($urandom), 8'($urandom));
  endtask

  task automatic finish_stream();
    send(klm_pkg::CMD_END, 4'($urandom), 4'($urandom), 8'($urandom), 5'($urandom),
         8'($urandom));
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(klm_pkg::klm_reg_t r, logic [31:0] val);
    psel   <= 1;
    pwrite <= 1;
    paddr  <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1, 2: return 8'h41;
      3, 4:    return 8'h42;
      5:       return 8'h43;
      6:       return klm_pkg::WILDCARD;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int eff(int k);
    return (kw_len[k] > 16) ? 16 : int'(kw_len[k]);
  endfunction

  // padded code, as the walk sees positions past the end
  function automatic int padded(int k, int p);
    return (p < eff(k)) ? int'(kw_chr[k][p]) : 0;
  endfunction

  // builds a sorted table; the first load writes every cell, later ones only
  // the positions inside each keyword
  task automatic load_table(bit full);
    logic [7:0] tc [16];
    logic [4:0] tl;
    int         cmp;
    for (int e = 0; e < 16; e++) begin
      case ($urandom_range(19))
        0:       kw_len[e] = 5'($urandom_range(17, 31));
        1:       kw_len[e] = 5'd0;
        2:       kw_len[e] = 5'($urandom_range(5, 16));
        default: kw_len[e] = 5'($urandom_range(1, 4));
      endcase
      for (int p = 0; p < 16; p++) kw_chr[e][p] = pick_char();
    end
    for (int a = 0; a < 15; a++)
      for (int b = 0; b < 15 - a; b++) begin
        cmp = 0;
        for (int p = 0; p < 16 && cmp == 0; p++)
          if (padded(b, p) != padded(b + 1, p)) cmp = padded(b, p) > padded(b + 1, p) ? 1 : -1;
        if (cmp > 0) begin
          tc = kw_chr[b]; kw_chr[b] = kw_chr[b + 1]; kw_chr[b + 1] = tc;
          tl = kw_len[b]; kw_len[b] = kw_len[b + 1]; kw_len[b + 1] = tl;
        end
      end
    for (int e = 0; e < 16; e++) begin
      for (int p = 0; p < 16; p++)
        if (full || p < eff(e))
          send(klm_pkg::CMD_LOAD_CHR, 4'(e), 4'(p), kw_chr[e][p], 5'($urandom),
               8'($urandom));
      send(klm_pkg::CMD_LOAD_LEN, 4'(e), 4'($urandom), 8'($urandom), kw_len[e],
           8'($urandom));
    end
  endtask

  task automatic stream_word(int k);
    logic [7:0] ch;
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        put_char($urandom_range(1) ? klm_pkg::SPACE
                                   : 8'($urandom_range(klm_pkg::WS_LO, klm_pkg::WS_HI)));
    for (int p = 0; p < eff(k) && p < $urandom_range(17, 30) - 14; p++) begin
      ch = kw_chr[k][p];
      if (ch == klm_pkg::WILDCARD && $urandom_range(1)) ch = 8'($urandom);
      if (fold_on && ch >= 8'h41 && ch <= 8'h5A && $urandom_range(1))
        ch = ch + klm_pkg::CASE_OFS;
      put_char(ch);
    end
    case ($urandom_range(9))
      0, 1, 2, 3: finish_stream();
      4, 5, 6:    put_char(pick_char());
      7:          send(klm_pkg::CMD_LOAD_CHR, 4'($urandom), 4'($urandom), pick_char(),
                       5'($urandom), 8'($urandom));
      default: ;
    endcase
  endtask

  initial begin
    int          kc;
    logic [7:0]  fold_set [6] = '{1, 0, 1, 0, 1, 1};
    logic [7:0]  skip_set [6] = '{1, 0, 0, 1, 1, 0};
    logic [7:0]  dflt_set [6] = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h01, 8'h80};
    logic [4:0]  cnt_set  [6] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd5, 5'd16};

    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty table, reset settings
    finish_stream();
    put_char(klm_pkg::SPACE);
    put_char(8'h0D);
    put_char(8'h41);
    put_char(8'h09);
    finish_stream();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      fold_on = fold_set[ph][0];
      reg_write(klm_pkg::REG_CASE_FOLD, {31'd0, fold_set[ph][0]});
      reg_write(klm_pkg::REG_SKIP_WHITE, {31'd0, skip_set[ph][0]});
      reg_write(klm_pkg::REG_DEFAULT_ID, {24'd0, dflt_set[ph]});
      // table is loaded while no entry is valid
      reg_write(klm_pkg::REG_KEY_COUNT, 32'd0);
      load_table(ph == 0);
      drain();
      reg_write(klm_pkg::REG_KEY_COUNT, {27'd0, cnt_set[ph]});
      kc = (cnt_set[ph] > 16) ? 16 : int'(cnt_set[ph]);
      if (ph == 0)
        for (int e = 0; e < 16; e++) stream_word(e);
      for (int it = 0; it < 40; it++) begin
        case ($urandom_range(9))
          0: put_char(8'($urandom));
          1: send(klm_pkg::klm_cmd_t'($urandom_range(3)), 4'($urandom), 4'($urandom),
                  8'($urandom), 5'($urandom), 8'($urandom));
          2: begin
            repeat ($urandom_range(1, 4)) put_char(pick_char());
            finish_stream();
          end
          default: stream_word(kc == 0 ? $urandom_range(15) : $urandom_range(kc - 1));
        endcase
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
